// ===== hw/rtl/mrmc_pkg.sv =====
package mrmc_pkg;

  localparam int unsigned AddrW  = 64;
  localparam int unsigned PagesW = 52;
  localparam int unsigned TypeW  = 4;
  localparam int unsigned KindW  = 3;
  localparam int unsigned IndexW = 7;
  localparam int unsigned PageShift = 12;

  typedef enum logic [KindW-1:0] {
    KindNone     = 3'd0,
    KindRam      = 3'd1,
    KindReserved = 3'd2,
    KindAcpi     = 3'd3,
    KindNvs      = 3'd4,
    KindUnusable = 3'd5
  } e820_kind_e;

  typedef struct packed {
    logic [AddrW-1:0]  addr;
    logic [AddrW-1:0]  size;
    e820_kind_e        kind;
    logic [IndexW-1:0] index;
    logic              valid;
    logic              fin;
  } mrmc_entry_t;

  // up to two results per descriptor; push1 is only set together with push0
  typedef struct packed {
    logic        push0;
    logic        push1;
    mrmc_entry_t entry0;
    mrmc_entry_t entry1;
  } mrmc_push_t;

  function automatic e820_kind_e efi_to_kind(input logic [TypeW-1:0] efi_type);
    e820_kind_e kind;
    case (efi_type)
      4'd1, 4'd2, 4'd3, 4'd4, 4'd7: kind = KindRam;
      4'd8:                         kind = KindUnusable;
      4'd9:                         kind = KindAcpi;
      4'd10:                        kind = KindNvs;
      default:                      kind = KindReserved;
    endcase
    return kind;
  endfunction

endpackage

// ===== hw/rtl/mrmc_merge.sv =====
module mrmc_merge import mrmc_pkg::*; #(
  parameter int unsigned MAX_ENTRIES = 128
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [AddrW-1:0]  phys_start_i,
  input  logic [PagesW-1:0] page_count_i,
  input  logic [TypeW-1:0]  efi_type_i,
  input  logic              last_descriptor_i,
  input  logic              space_ok_i,
  output mrmc_push_t        push_o
);

  localparam int unsigned CntW = $clog2(MAX_ENTRIES + 1);
  localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_ENTRIES);

  logic              in_vld_q;
  logic [AddrW-1:0]  start_q;
  logic [PagesW-1:0] pages_q;
  logic [TypeW-1:0]  type_q;
  logic              last_q;

  logic [AddrW-1:0]  paddr_q, paddr_d;
  logic [AddrW-1:0]  psize_q, psize_d;
  e820_kind_e        pkind_q, pkind_d;
  logic [CntW-1:0]   count_q, count_d;

  logic              advance;
  logic              take, merge, has_pend, close;
  logic [AddrW-1:0]  size;
  e820_kind_e        kind;
  logic [AddrW-1:0]  naddr, nsize;
  e820_kind_e        nkind;
  logic [CntW-1:0]   ncount;
  logic [CntW-1:0]   close_idx, flush_idx;
  logic [CntW+IndexW-1:0] close_ext, flush_ext;
  mrmc_entry_t       close_e, flush_e;

  assign advance    = in_vld_q && space_ok_i;
  assign in_ready_o = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      start_q <= phys_start_i;
      pages_q <= page_count_i;
      type_q  <= efi_type_i;
      last_q  <= last_descriptor_i;
    end
  end

  always_comb begin
    kind     = efi_to_kind(type_q);
    size     = {pages_q, PageShift'(0)};
    has_pend = count_q != '0;
    take     = (pages_q != '0) && (count_q < MaxCnt);
    merge    = has_pend && ((paddr_q + psize_q) == start_q) && (pkind_q == kind);
    close    = take && !merge && has_pend;

    naddr  = paddr_q;
    nsize  = psize_q;
    nkind  = pkind_q;
    ncount = count_q;
    if (take && merge) begin
      nsize = psize_q + size;
    end else if (take) begin
      naddr  = start_q;
      nsize  = size;
      nkind  = kind;
      ncount = count_q + 1'b1;
    end

    close_idx = count_q - 1'b1;
    flush_idx = ncount - 1'b1;
    close_ext = {{IndexW{1'b0}}, close_idx};
    flush_ext = {{IndexW{1'b0}}, flush_idx};

    close_e.addr  = paddr_q;
    close_e.size  = psize_q;
    close_e.kind  = pkind_q;
    close_e.index = close_ext[IndexW-1:0];
    close_e.valid = 1'b1;
    close_e.fin   = 1'b0;

    if (ncount != '0) begin
      flush_e.addr  = naddr;
      flush_e.size  = nsize;
      flush_e.kind  = nkind;
      flush_e.index = flush_ext[IndexW-1:0];
      flush_e.valid = 1'b1;
    end else begin
      flush_e.addr  = '0;
      flush_e.size  = '0;
      flush_e.kind  = KindNone;
      flush_e.index = '0;
      flush_e.valid = 1'b0;
    end
    flush_e.fin = 1'b1;

    push_o.push0  = advance && (close || last_q);
    push_o.push1  = advance && close && last_q;
    push_o.entry0 = close ? close_e : flush_e;
    push_o.entry1 = flush_e;

    paddr_d = naddr;
    psize_d = nsize;
    pkind_d = nkind;
    count_d = ncount;
    if (last_q) begin
      paddr_d = '0;
      psize_d = '0;
      pkind_d = KindNone;
      count_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      paddr_q <= '0;
      psize_q <= '0;
      pkind_q <= KindNone;
      count_q <= '0;
    end else if (advance) begin
      paddr_q <= paddr_d;
      psize_q <= psize_d;
      pkind_q <= pkind_d;
      count_q <= count_d;
    end
  end

endmodule

// ===== hw/rtl/mrmc_queue.sv =====
module mrmc_queue import mrmc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  mrmc_push_t  push_i,
  output logic        space_ok_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output mrmc_entry_t out_entry_o
);

  localparam int unsigned Depth = 4;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  mrmc_entry_t       mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   count_q, count_d;
  logic              pop;
  logic [PtrW-1:0]   wr_ptr_nx;

  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = count_q != '0;
  assign out_entry_o = mem_q[rd_ptr_q];
  assign space_ok_o  = count_q <= CntW'(Depth - 2);
  assign wr_ptr_nx   = wr_ptr_q + 1'b1;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    if (push_i.push1) begin
      wr_ptr_d = wr_ptr_q + PtrW'(2);
    end else if (push_i.push0) begin
      wr_ptr_d = wr_ptr_nx;
    end
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q + CntW'(push_i.push0) + CntW'(push_i.push1) - CntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.push0) begin
      mem_q[wr_ptr_q] <= push_i.entry0;
    end
    if (push_i.push1) begin
      mem_q[wr_ptr_nx] <= push_i.entry1;
    end
  end

endmodule

// ===== hw/rtl/memory_region_map_coalescer.sv =====
// Converts a stream of UEFI memory descriptors into a coalesced E820 map.
// Each descriptor (start address, page count, UEFI type) is mapped to an E820
// kind; a descriptor that starts where the pending entry ends and has the same
// kind extends it, anything else emits the pending entry and opens a new one.
// Zero-page descriptors are dropped and, once MAX_ENTRIES entries are open,
// further descriptors are ignored. tlast on a descriptor flushes the pending
// entry with tlast set on the result (tuser valid bit low if the map is
// empty) and clears the block for the next map. One descriptor is taken per
// cycle while the queue has room; it sits in the input register and its results
// then wait in a four-entry result queue. A descriptor that both closes an
// entry and flushes yields two results, and the queue drains one result per
// cycle if m_axis_tready_i is high; input back pressure follows the fill level.
module memory_region_map_coalescer import mrmc_pkg::*; #(
  parameter int unsigned MAX_ENTRIES = 128
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [119:0] s_axis_tdata_i,   // phys_start[63:0], page_count[115:64], zero pad
  input  logic [3:0]   s_axis_tuser_i,   // efi_type[3:0]
  input  logic         s_axis_tlast_i,   // last_descriptor
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  output logic [135:0] m_axis_tdata_o,   // entry_addr[63:0], entry_size[127:64],
                                         // entry_index[134:128], zero pad
  output logic [3:0]   m_axis_tuser_o,   // entry_kind[2:0], entry_valid[3]
  output logic         m_axis_tlast_o    // final_entry
);

  mrmc_push_t  push;
  mrmc_entry_t entry;
  logic        space_ok;

  mrmc_merge #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) u_merge (
    .clk_i,
    .rst_ni,
    .in_valid_i        (s_axis_tvalid_i),
    .in_ready_o        (s_axis_tready_o),
    .phys_start_i      (s_axis_tdata_i[63:0]),
    .page_count_i      (s_axis_tdata_i[115:64]),
    .efi_type_i        (s_axis_tuser_i),
    .last_descriptor_i (s_axis_tlast_i),
    .space_ok_i        (space_ok),
    .push_o            (push)
  );

  mrmc_queue u_queue (
    .clk_i,
    .rst_ni,
    .push_i      (push),
    .space_ok_o  (space_ok),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_entry_o (entry)
  );

  assign m_axis_tdata_o = {1'b0, entry.index, entry.size, entry.addr};
  assign m_axis_tuser_o = {entry.valid, entry.kind};
  assign m_axis_tlast_o = entry.fin;

endmodule
